/* src/mpeg_audio_header_scan_decode_top_assert.svh */
// Assertion macros for the header scan top level.
`ifndef MPEG_AUDIO_HEADER_SCAN_DECODE_TOP_ASSERT_SVH
`define MPEG_AUDIO_HEADER_SCAN_DECODE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define MAHSD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define MAHSD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mahsd_pkg.sv */
package mahsd_pkg;

   localparam int SCAN_LIMIT = 65536;
   localparam int POS_W      = $clog2(SCAN_LIMIT + 4);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(SCAN_LIMIT + 3);

   localparam int DIVD_W    = 32;
   localparam int DIVR_W    = 17;
   localparam int DIV_CNT_W = $clog2(DIVD_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   localparam logic [15:0] SYNC_MASK_RST    = 16'hfffe;
   localparam logic [15:0] SYNC_PATTERN_RST = 16'hfffa;

   localparam logic [31:0] LAYER_I_FACTOR  = 32'd12000;
   localparam logic [31:0] LAYER_XX_FACTOR = 32'd144000;
   localparam logic [DIVR_W-1:0] KBPS_TO_BYTES = DIVR_W'(125);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_MASK    = 2'd0,
      CSR_SYNC_PATTERN = 2'd1,
      CSR_DATA_LENGTH  = 2'd2
   } csr_index_type;

   localparam logic [1:0] VER_25  = 2'd0;
   localparam logic [1:0] VER_RSV = 2'd1;
   localparam logic [1:0] VER_2   = 2'd2;
   localparam logic [1:0] VER_1   = 2'd3;

   localparam logic [1:0] LAYER_RSV = 2'd0;
   localparam logic [1:0] LAYER_III = 2'd1;
   localparam logic [1:0] LAYER_II  = 2'd2;
   localparam logic [1:0] LAYER_I   = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_data_type;

   typedef struct packed {
      logic        found;
      logic [15:0] header_offset;
      logic [1:0]  mpeg_version;
      logic [1:0]  layer_code;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic        padding;
      logic [11:0] frame_bytes;
      logic [22:0] play_seconds;
   } rsp_data_type;

   typedef struct packed {
      logic        found;
      logic [15:0] offset;
      logic [1:0]  ver;
      logic [1:0]  layer;
      logic [3:0]  bidx;
      logic [1:0]  fidx;
      logic        pad;
   } job_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FRAME_GO,
      ST_FRAME_WAIT,
      ST_SECS_GO,
      ST_SECS_WAIT,
      ST_SEND
   } back_state_type;

   localparam logic [8:0] KBPS_TABLE [0:79] = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0,
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0,
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0,
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0,
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
   };

   localparam logic [15:0] RATE_TABLE [0:11] = '{
      16'd44100, 16'd48000, 16'd32000, 16'd0,
      16'd22050, 16'd24000, 16'd16000, 16'd0,
      16'd11025, 16'd12000, 16'd8000, 16'd0
   };

   function automatic logic [8:0] kbps_lookup(input logic [1:0] ver,
                                              input logic [1:0] layer,
                                              input logic [3:0] bidx);
      logic [2:0] row;
      logic       ok;
      row = 3'd0;
      ok  = 1'b0;
      if (layer != LAYER_RSV) begin
         if (ver == VER_1) begin
            ok = 1'b1;
            unique case (layer)
               LAYER_I:  row = 3'd0;
               LAYER_II: row = 3'd1;
               default:  row = 3'd2;
            endcase
         end else if (ver == VER_2 || ver == VER_25) begin
            ok  = 1'b1;
            row = (layer == LAYER_I) ? 3'd3 : 3'd4;
         end
      end
      return ok ? KBPS_TABLE[{row, bidx}] : 9'd0;
   endfunction

   function automatic logic [15:0] rate_lookup(input logic [1:0] ver,
                                               input logic [1:0] fidx);
      logic [1:0] sel;
      logic       ok;
      sel = 2'd0;
      ok  = 1'b1;
      unique case (ver)
         VER_1:   sel = 2'd0;
         VER_2:   sel = 2'd1;
         VER_25:  sel = 2'd2;
         default: ok  = 1'b0;
      endcase
      return ok ? RATE_TABLE[{sel, fidx}] : 16'd0;
   endfunction

endpackage

/* src/mpeg_audio_header_scan_decode_top.sv */
// port   dir  payload        beat when
// req_*  in   req_data_type  req_valid & !req_stall
// rsp_*  out  rsp_data_type  rsp_valid & !rsp_stall
// csr_*  in   index + 32b    csr_we
//
// Bytes enter at one per cycle; the scanner stalls only when its 2-entry job queue is full.
// A found header's result follows table decode, then two passes through the shared
// bit-serial divider (frame length, then play time).
// A no-header result skips decode and the divider; the controller goes from idle to send.
// Synchronous reset clears scan state, queue and controller; no clearing pass.
// rsp_stall holds the result register; the scanner keeps taking bytes until the queue fills.
`include "mpeg_audio_header_scan_decode_top_assert.svh"

module mpeg_audio_header_scan_decode_top
   import mahsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_data_type         req_data,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output rsp_data_type         rsp_data,
   input  logic                 rsp_stall,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [15:0] sync_mask_ff;
   logic [15:0] sync_pattern_ff;
   logic [31:0] data_length_ff;

   logic        push, pop, q_full, q_empty;
   job_type     push_job, pop_job;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_mask_ff    <= SYNC_MASK_RST;
         sync_pattern_ff <= SYNC_PATTERN_RST;
         data_length_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_MASK:    sync_mask_ff    <= csr_wdata[15:0];
            CSR_SYNC_PATTERN: sync_pattern_ff <= csr_wdata[15:0];
            CSR_DATA_LENGTH:  data_length_ff  <= csr_wdata[31:0];
            default:          data_length_ff  <= data_length_ff;
         endcase
      end
   end

   mahsd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .sync_mask    (sync_mask_ff),
      .sync_pattern (sync_pattern_ff),
      .q_full       (q_full),
      .push         (push),
      .job          (push_job)
   );

   mahsd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (push_job),
      .pop   (pop),
      .dout  (pop_job),
      .full  (q_full),
      .empty (q_empty)
   );

   mahsd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mahsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (pop_job),
      .pop         (pop),
      .data_length (data_length_ff),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `MAHSD_ASSERT_IMP(a_miss_is_blank, rsp_valid && !rsp_data.found,
      rsp_data.header_offset == '0 && rsp_data.bitrate_kbps == '0 &&
      rsp_data.frame_bytes == '0 && rsp_data.play_seconds == '0,
      "no-header result carries nonzero fields")
   `MAHSD_ASSERT_IMP(a_free_rate_no_time, rsp_valid && rsp_data.bitrate_kbps == '0,
      rsp_data.play_seconds == '0, "play time without bitrate")
   `MAHSD_ASSERT_IMP(a_no_rate_no_frame, rsp_valid && rsp_data.sample_rate_hz == '0,
      rsp_data.frame_bytes == '0, "frame length without sample rate")
   `MAHSD_ASSERT_NXT(a_gap_after_beat, rsp_valid && !rsp_stall, !rsp_valid,
      "result repeated after beat")

endmodule

/* src/mahsd_front.sv */
module mahsd_front
   import mahsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_data_type req_data,
   output logic         req_stall,
   input  logic [15:0]  sync_mask,
   input  logic [15:0]  sync_pattern,
   input  logic         q_full,
   output logic         push,
   output job_type      job
);

   logic [23:0]      window_ff, window_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             closed_ff, closed_in;

   logic             accept;
   logic [23:0]      win_eff;
   logic [POS_W-1:0] pos_eff;
   logic             closed_eff;
   logic [31:0]      hdr;
   logic [POS_W-1:0] hpos;
   logic             hit;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      win_eff    = req_data.first_byte ? 24'd0 : window_ff;
      pos_eff    = req_data.first_byte ? '0 : pos_ff;
      closed_eff = req_data.first_byte ? 1'b0 : closed_ff;
      hdr        = {win_eff, req_data.data_byte};
      hpos       = pos_eff - POS_W'(3);
      hit        = (pos_eff >= POS_W'(3)) && (pos_eff < POS_MAX) &&
                   ((hdr[31:16] & sync_mask) == sync_pattern);
      window_in  = window_ff;
      pos_in     = pos_ff;
      closed_in  = closed_ff;
      push       = 1'b0;
      job        = '0;
      if (accept) begin
         window_in = win_eff;
         pos_in    = pos_eff;
         closed_in = closed_eff;
         if (!closed_eff) begin
            window_in = hdr[23:0];
            if (pos_eff < POS_MAX) begin
               pos_in = pos_eff + POS_W'(1);
            end
            if (hit) begin
               push       = 1'b1;
               closed_in  = 1'b1;
               job.found  = 1'b1;
               job.offset = 16'(hpos);
               job.ver    = hdr[20:19];
               job.layer  = hdr[18:17];
               job.bidx   = hdr[15:12];
               job.fidx   = hdr[11:10];
               job.pad    = hdr[9];
            end else if (req_data.last_byte) begin
               push      = 1'b1;
               closed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         closed_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         closed_ff <= closed_in;
      end
   end

endmodule

/* src/mahsd_queue.sv */
module mahsd_queue
   import mahsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   input  logic    pop,
   output job_type dout,
   output logic    full,
   output logic    empty
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/mahsd_div.sv */
module mahsd_div
   import mahsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DIVR_W-1:0]    divisor_ff, divisor_in;

   logic [DIVR_W:0]      trial;
   logic [DIVR_W:0]      diff;
   logic                 ge;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial      = {rem_ff, quo_ff[DIVD_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      ge         = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(DIVD_W - 1);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* src/mahsd_back.sv */
module mahsd_back
   import mahsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  job_type      q_job,
   output logic         pop,
   input  logic [31:0]  data_length,
   output div_req_type  div_req,
   input  div_rsp_type  div_rsp,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [8:0]     kbps_ff;
   logic [15:0]    rate_ff;
   logic [11:0]    flen_ff, flen_in;
   logic [22:0]    secs_ff, secs_in;

   logic           load_job, load_tab, load_flen, load_secs;
   logic           v2x;
   logic [11:0]    flen_base;

   assign v2x       = (job_ff.ver == VER_2) || (job_ff.ver == VER_25);
   assign flen_base = div_rsp.quotient[11:0] + 12'(job_ff.pad);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = q_job.found ? ST_DECODE : ST_SEND;
            end
         end
         ST_DECODE:     state_in = ST_FRAME_GO;
         ST_FRAME_GO:   state_in = ST_FRAME_WAIT;
         ST_FRAME_WAIT: if (div_rsp.done) state_in = ST_SECS_GO;
         ST_SECS_GO:    state_in = ST_SECS_WAIT;
         ST_SECS_WAIT:  if (div_rsp.done) state_in = ST_SEND;
         ST_SEND:       if (!rsp_stall) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop              = 1'b0;
      load_job         = 1'b0;
      load_tab         = 1'b0;
      load_flen        = 1'b0;
      load_secs        = 1'b0;
      rsp_valid        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            pop      = !q_empty;
            load_job = !q_empty;
         end
         ST_DECODE: load_tab = 1'b1;
         ST_FRAME_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(kbps_ff) *
                               ((job_ff.layer == LAYER_I) ? LAYER_I_FACTOR : LAYER_XX_FACTOR);
            div_req.divisor  = (job_ff.layer == LAYER_III && v2x) ?
                               {rate_ff, 1'b0} : DIVR_W'(rate_ff);
         end
         ST_FRAME_WAIT: load_flen = div_rsp.done;
         ST_SECS_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = data_length;
            div_req.divisor  = DIVR_W'(kbps_ff) * KBPS_TO_BYTES;
         end
         ST_SECS_WAIT: load_secs = div_rsp.done;
         ST_SEND:      rsp_valid = 1'b1;
         default:      rsp_valid = 1'b0;
      endcase
   end

   always_comb begin
      flen_in = 12'd0;
      if (rate_ff != 16'd0 && job_ff.layer != LAYER_RSV) begin
         flen_in = (job_ff.layer == LAYER_I) ? {flen_base[9:0], 2'b00} : flen_base;
      end
      secs_in = (kbps_ff != 9'd0) ? div_rsp.quotient[22:0] : 23'd0;
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff  <= q_job;
         kbps_ff <= '0;
         rate_ff <= '0;
         flen_ff <= '0;
         secs_ff <= '0;
      end else begin
         if (load_tab) begin
            kbps_ff <= kbps_lookup(job_ff.ver, job_ff.layer, job_ff.bidx);
            rate_ff <= rate_lookup(job_ff.ver, job_ff.fidx);
         end
         if (load_flen) begin
            flen_ff <= flen_in;
         end
         if (load_secs) begin
            secs_ff <= secs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_data.found          = job_ff.found;
   assign rsp_data.header_offset  = job_ff.offset;
   assign rsp_data.mpeg_version   = job_ff.ver;
   assign rsp_data.layer_code     = job_ff.layer;
   assign rsp_data.bitrate_kbps   = kbps_ff;
   assign rsp_data.sample_rate_hz = rate_ff;
   assign rsp_data.padding        = job_ff.pad;
   assign rsp_data.frame_bytes    = flen_ff;
   assign rsp_data.play_seconds   = secs_ff;

endmodule

/* tb/sv/header_scan_checker.sv */
module header_scan_checker
   import mahsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_data_type         req_data,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  rsp_data_type         rsp_data,
   input  logic                 rsp_stall,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   error_count,
   output int                   open_results,
   output int                   scanned_bytes
);

   // rows: v1 layer I, v1 layer II, v1 layer III, v2/v2.5 layer I, v2/v2.5 layer II/III
   localparam int unsigned BITRATE_KBPS [0:79] = '{
      0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0,
      0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0,
      0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0,
      0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0,
      0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0
   };

   localparam int unsigned SAMPLE_HZ [0:11] = '{
      44100, 48000, 32000, 0,
      22050, 24000, 16000, 0,
      11025, 12000, 8000, 0
   };

   logic [15:0]  sync_mask;
   logic [15:0]  sync_pattern;
   logic [31:0]  data_length;
   logic [23:0]  last_bytes;
   int unsigned  position;
   logic         scan_closed;
   rsp_data_type results_due [$];

   function automatic rsp_data_type decode_header(input logic [31:0] hdr,
                                                  input int unsigned offset);
      rsp_data_type r;
      logic [1:0]   ver;
      logic [1:0]   layer;
      logic [1:0]   fidx;
      logic [3:0]   bidx;
      logic         pad;
      logic         v1;
      logic         v2x;
      int unsigned  kbps;
      int unsigned  rate;
      int unsigned  bps;
      int unsigned  flen;
      int unsigned  secs;
      ver   = hdr[20:19];
      layer = hdr[18:17];
      bidx  = hdr[15:12];
      fidx  = hdr[11:10];
      pad   = hdr[9];
      kbps  = 0;
      rate  = 0;
      flen  = 0;
      secs  = 0;
      v1    = (ver == VER_1);
      v2x   = (ver == VER_2) || (ver == VER_25);
      if (layer != LAYER_RSV) begin
         if (v1)
            kbps = BITRATE_KBPS[(3 - layer) * 16 + bidx];
         else if (v2x)
            kbps = BITRATE_KBPS[((layer == LAYER_I) ? 48 : 64) + bidx];
      end
      case (ver)
         VER_1:   rate = SAMPLE_HZ[fidx];
         VER_2:   rate = SAMPLE_HZ[4 + fidx];
         VER_25:  rate = SAMPLE_HZ[8 + fidx];
         default: rate = 0;
      endcase
      bps = kbps * 1000;
      if (rate != 0) begin
         if (layer == LAYER_I)
            flen = ((12 * bps) / rate + pad) * 4;
         else if (layer == LAYER_II)
            flen = (144 * bps) / rate + pad;
         else if (layer == LAYER_III)
            flen = v2x ? (144 * bps) / (rate * 2) + pad : (144 * bps) / rate + pad;
      end
      if (kbps != 0)
         secs = data_length / (kbps * 125);
      r                = '0;
      r.found          = 1'b1;
      r.header_offset  = offset[15:0];
      r.mpeg_version   = ver;
      r.layer_code     = layer;
      r.bitrate_kbps   = kbps[8:0];
      r.sample_rate_hz = rate[15:0];
      r.padding        = pad;
      r.frame_bytes    = flen[11:0];
      r.play_seconds   = secs[22:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_data_type want;
      logic [31:0]  hdr;
      int unsigned  at;
      if (reset) begin
         sync_mask     = SYNC_MASK_RST;
         sync_pattern  = SYNC_PATTERN_RST;
         data_length   = '0;
         last_bytes    = '0;
         position      = 0;
         scan_closed   = 1'b0;
         error_count   = 0;
         scanned_bytes = 0;
         results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_MASK:    sync_mask    = csr_wdata[15:0];
               CSR_SYNC_PATTERN: sync_pattern = csr_wdata[15:0];
               CSR_DATA_LENGTH:  data_length  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with none expected, got %h", $time, rsp_data);
               error_count++;
            end else begin
               want = results_due.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("header_offset", 32'(want.header_offset),
                           32'(rsp_data.header_offset));
               check_field("mpeg_version", 32'(want.mpeg_version),
                           32'(rsp_data.mpeg_version));
               check_field("layer_code", 32'(want.layer_code), 32'(rsp_data.layer_code));
               check_field("bitrate_kbps", 32'(want.bitrate_kbps),
                           32'(rsp_data.bitrate_kbps));
               check_field("sample_rate_hz", 32'(want.sample_rate_hz),
                           32'(rsp_data.sample_rate_hz));
               check_field("padding", 32'(want.padding), 32'(rsp_data.padding));
               check_field("frame_bytes", 32'(want.frame_bytes),
                           32'(rsp_data.frame_bytes));
               check_field("play_seconds", 32'(want.play_seconds),
                           32'(rsp_data.play_seconds));
            end
         end
         if (req_valid && !req_stall) begin
            scanned_bytes++;
            if (req_data.first_byte) begin
               last_bytes  = '0;
               position    = 0;
               scan_closed = 1'b0;
            end
            if (!scan_closed) begin
               at         = position;
               hdr        = {last_bytes, req_data.data_byte};
               last_bytes = hdr[23:0];
               if (position < SCAN_LIMIT + 3)
                  position++;
               if (at >= 3 && at - 3 < SCAN_LIMIT &&
                   (hdr[31:16] & sync_mask) == sync_pattern) begin
                  scan_closed = 1'b1;
                  results_due.insert(results_due.size(), decode_header(hdr, at - 3));
               end else if (req_data.last_byte) begin
                  scan_closed = 1'b1;
                  want        = '0;
                  results_due.insert(results_due.size(), want);
               end
            end
         end
      end
      open_results = results_due.size();
   end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   import mahsd_pkg::*;

   localparam int RANDOM_BYTES = 1550;
   localparam int PHASE_BYTES  = 200;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1500000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   req_data_type         req_data;
   logic                 req_stall;
   logic                 rsp_valid;
   rsp_data_type         rsp_data;
   logic                 rsp_stall;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   int          error_count;
   int          open_results;
   int          scanned_bytes;
   int          cycle_count = 0;
   bit          no_gaps = 1'b0;
   logic [15:0] cur_mask = SYNC_MASK_RST;
   logic [15:0] cur_pattern = SYNC_PATTERN_RST;

   mpeg_audio_header_scan_decode_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   header_scan_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .rsp_stall     (rsp_stall),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .open_results  (open_results),
      .scanned_bytes (scanned_bytes)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the beat, valid still high
   task automatic send_beat(input logic [7:0] b, input logic first, input logic last);
      int unsigned  gap;
      req_data_type beat;
      gap             = no_gaps ? 0 : $urandom_range(0, 7);
      beat.data_byte  = b;
      beat.first_byte = first;
      beat.last_byte  = last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] mask, input logic [15:0] pattern,
                             input logic [31:0] len);
      settle();
      cur_mask    = mask;
      cur_pattern = pattern;
      csr_we      <= 1'b1;
      csr_index   <= CSR_SYNC_MASK;
      csr_wdata   <= {16'h0, mask};
      @(negedge clock);
      csr_index   <= CSR_SYNC_PATTERN;
      csr_wdata   <= {16'h0, pattern};
      @(negedge clock);
      csr_index   <= CSR_DATA_LENGTH;
      csr_wdata   <= len;
      @(negedge clock);
      csr_we      <= 1'b0;
   endtask

   // mostly well-formed files carrying a sync pair; some noise and broken files
   task automatic send_file();
      int unsigned kind;
      int unsigned len;
      int unsigned at;
      int unsigned i;
      logic [7:0]  body [$];
      logic [15:0] sync;
      logic        noise;
      kind  = $urandom_range(0, 9);
      noise = (kind == 0);
      if (noise)
         len = $urandom_range(1, 12);
      else if ($urandom_range(0, 4) == 0)
         len = $urandom_range(1, 40);
      else
         len = $urandom_range(4, 12);
      for (i = 0; i < len; i++)
         body.insert(body.size(), 8'($urandom_range(0, 255)));
      if (!noise && kind != 1 && len >= 4) begin
         at = (kind == 4) ? len - 2 : $urandom_range(0, len - 4);
         sync = cur_pattern | (16'($urandom) & ~cur_mask);
         body[at]     = sync[15:8];
         body[at + 1] = sync[7:0];
      end
      for (i = 0; i < len; i++) begin
         if (noise)
            send_beat(body[i], $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         else
            send_beat(body[i], i == 0 && kind != 3, i == len - 1 && kind != 2);
      end
   endtask

   initial begin : rsp_side
      int unsigned hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = no_gaps ? 0 : $urandom_range(0, 7);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            while (hold != 0) begin
               @(posedge clock);
               if (rsp_valid)
                  hold--;
            end
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin : req_side
      int          base;
      int          mark;
      logic [15:0] mask;
      logic [15:0] pattern;
      logic [31:0] len;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_SYNC_MASK;
      csr_wdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      set_config(SYNC_MASK_RST, SYNC_PATTERN_RST, 32'hffff_ffff);
      send_beat(8'hff, 1'b1, 1'b0);
      send_beat(8'hfb, 1'b0, 1'b0);
      send_beat(8'h90, 1'b0, 1'b0);
      send_beat(8'h64, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);   // scan closed, ignored
      send_beat(8'h00, 1'b1, 1'b0);   // sync pair in the tail only
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(8'hfa, 1'b0, 1'b1);
      send_beat(8'h55, 1'b1, 1'b1);
      send_beat(8'hff, 1'b1, 1'b0);   // header ends on last byte, padding set
      send_beat(8'hfa, 1'b0, 1'b0);
      send_beat(8'h02, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);

      set_config(16'hffe0, 16'hffe0, 32'h0);
      send_beat(8'hff, 1'b1, 1'b0);   // reserved version and layer
      send_beat(8'he8, 1'b0, 1'b0);
      send_beat(8'hf0, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hff, 1'b1, 1'b0);   // v2.5 layer III, reserved rate
      send_beat(8'he2, 1'b0, 1'b0);
      send_beat(8'hed, 1'b0, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'hff, 1'b1, 1'b0);   // v2 layer I
      send_beat(8'hf6, 1'b0, 1'b0);
      send_beat(8'ha6, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hff, 1'b1, 1'b0);   // v1 layer II, top bitrate
      send_beat(8'hfd, 1'b0, 1'b0);
      send_beat(8'he8, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);

      set_config(16'h0000, 16'h0000, 32'd1000);
      send_beat(8'h12, 1'b1, 1'b0);
      send_beat(8'h34, 1'b0, 1'b0);
      send_beat(8'h56, 1'b0, 1'b0);
      send_beat(8'h78, 1'b0, 1'b1);

      base = scanned_bytes;
      while (scanned_bytes - base < RANDOM_BYTES) begin
         case ($urandom_range(0, 5))
            0: begin mask = SYNC_MASK_RST; pattern = SYNC_PATTERN_RST; end
            1: begin mask = 16'hffe0; pattern = 16'hffe0; end
            2: begin mask = 16'h0000; pattern = 16'h0000; end
            3: begin mask = 16'hffff; pattern = 16'hffff; end
            4: begin mask = 16'($urandom); pattern = 16'($urandom) & mask; end
            default: begin mask = 16'($urandom); pattern = 16'($urandom); end
         endcase
         case ($urandom_range(0, 3))
            0:       len = 32'h0;
            1:       len = 32'hffff_ffff;
            default: len = $urandom;
         endcase
         set_config(mask, pattern, len);
         no_gaps = ($urandom_range(0, 3) == 0);
         mark    = scanned_bytes;
         while (scanned_bytes - mark < PHASE_BYTES && scanned_bytes - base < RANDOM_BYTES)
            send_file();
      end

      settle();
      if (error_count == 0 && open_results == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/mahsd_pkg.sv
src/mahsd_front.sv
src/mahsd_queue.sv
src/mahsd_div.sv
src/mahsd_back.sv
src/mpeg_audio_header_scan_decode_top.sv
tb/sv/header_scan_checker.sv
tb/sv/tb_top.sv
